// ===== rtl/core/mma_pkg.sv =====
`timescale 1ns / 1ps

package mma_pkg;

  // Operand width; only the low OPERAND_BITS bits of each operand and of the
  // modulus take part in the arithmetic.
  localparam int OPERAND_BITS = 64;

  // Port width of every operand, result and configuration field.
  localparam int FIELD_W = 64;

  // The factors are split into two halves for the partial products.
  localparam int HALF_W = (OPERAND_BITS + 1) / 2;

  // Width of the exact product plus addend, padded to four halves.
  localparam int PROD_W = 4 * HALF_W;

  // One cell of the remainder chain per dividend bit.
  localparam int NUM_CELLS = PROD_W;

  // Pipeline depth of the multiply front end.
  localparam int MUL_STAGES = 3;

  // Modulus after reset.
  localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(2);

  // Data handed from one remainder cell to the next.
  typedef struct packed {
    logic                    valid;
    logic [OPERAND_BITS-1:0] rem;
    logic [PROD_W-1:0]       dvd;
  } cell_bus_t;

endpackage

// ===== rtl/core/mma_mul.sv =====
`timescale 1ns / 1ps

module mma_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [mma_pkg::OPERAND_BITS-1:0]    mult_left,
  input  logic [mma_pkg::OPERAND_BITS-1:0]    mult_right,
  input  logic [mma_pkg::OPERAND_BITS-1:0]    addend,
  output mma_pkg::cell_bus_t                  head
);

  localparam int HW = mma_pkg::HALF_W;
  localparam int PW = mma_pkg::PROD_W;

  logic [HW-1:0] a_lo, a_hi, b_lo, b_hi;

  // Stage one: four partial products.
  logic            v1_r;
  logic [2*HW-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [PW-1:0]   c1_r;

  // Stage two: middle sum, and outer products with the addend.
  logic            v2_r;
  logic [2*HW:0]   mid_r;
  logic [PW-1:0]   low_r;
  logic [2*HW:0]   mid_nxt;
  logic [PW-1:0]   low_nxt;

  // Stage three: the exact sum a*b + c.
  logic            v3_r;
  logic [PW-1:0]   sum_r;
  logic [PW-1:0]   sum_nxt;

  // Split the factors into halves.
  assign a_lo = HW'(mult_left);
  assign a_hi = HW'(mult_left >> HW);
  assign b_lo = HW'(mult_right);
  assign b_hi = HW'(mult_right >> HW);

  assign mid_nxt = (2*HW+1)'(lh_r) + (2*HW+1)'(hl_r);
  assign low_nxt = {hh_r, ll_r} + c1_r;
  assign sum_nxt = low_r + (PW'(mid_r) << HW);

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk) begin
    ll_r  <= a_lo * b_lo;
    lh_r  <= a_lo * b_hi;
    hl_r  <= a_hi * b_lo;
    hh_r  <= a_hi * b_hi;
    c1_r  <= PW'(addend);
    mid_r <= mid_nxt;
    low_r <= low_nxt;
    sum_r <= sum_nxt;
  end

  // The remainder chain starts from zero.
  assign head.valid = v3_r;
  assign head.rem   = '0;
  assign head.dvd   = sum_r;

`ifndef SYNTHESIS
  // An accepted transaction always comes out of the front end; none is lost.
  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 head.valid)
    else $error("multiply front end lost a transaction");
`endif

endmodule

// ===== rtl/core/mma_cell.sv =====
`timescale 1ns / 1ps

module mma_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mma_pkg::OPERAND_BITS-1:0]  modulus,
  input  mma_pkg::cell_bus_t                prev,
  output mma_pkg::cell_bus_t                next
);

  localparam int OW = mma_pkg::OPERAND_BITS;
  localparam int PW = mma_pkg::PROD_W;

  logic          valid_r;
  logic [OW-1:0] rem_r;
  logic [PW-1:0] dvd_r;

  logic [OW:0]   shifted;
  logic [OW:0]   diff;
  logic          take;
  logic [OW-1:0] rem_nxt;

  // Bring down the next dividend bit, subtract the modulus when it fits.
  assign shifted = {prev.rem, prev.dvd[PW-1]};
  assign diff    = shifted - {1'b0, modulus};
  assign take    = shifted >= {1'b0, modulus};
  assign rem_nxt = take ? diff[OW-1:0] : shifted[OW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= prev.dvd << 1;
  end

  assign next.valid = valid_r;
  assign next.rem   = rem_r;
  assign next.dvd   = dvd_r;

`ifndef SYNTHESIS
  // The partial remainder stays below any nonzero modulus.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (next.valid && modulus != '0) |-> (next.rem < modulus))
    else $error("partial remainder not reduced");

  // Every transaction moves one cell per cycle.
  a_cell_move: assert property (@(posedge clk) disable iff (!rst_n)
    prev.valid |=> next.valid)
    else $error("cell dropped a transaction");
`endif

endmodule

// ===== rtl/core/modular_multiply_add.sv =====
`timescale 1ns / 1ps

// Modular multiply-add: residue = (mult_left * mult_right + addend) mod modulus.
// Input: a transaction is taken at each clock edge with start high and busy
// low. busy is never raised, so one operand triple can enter every cycle.
// Output: each result appears on out_residue for one cycle with out_valid
// high; the receiver cannot stall it, so results must be taken as they come.
// Results leave in the order their operands came in.
// An accepted transaction passes through the pipelined split 64x64 multiply
// and addend sum, then through 128 cells that each reduce one bit of the
// 128-bit sum by shift and conditional subtract.
// Throughput is one transaction per cycle.
// The user must write the modulus through cfg_we/cfg_data only while no
// transaction is in flight; the block does not enforce it. A zero modulus
// gives a residue of zero. Reset (synchronous, active low) empties the
// pipeline and sets the modulus to two.
module modular_multiply_add (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_mult_left,
  input  logic [63:0] in_mult_right,
  input  logic [63:0] in_addend,
  output logic        out_valid,
  output logic [63:0] out_residue,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data
);

  localparam int OW = mma_pkg::OPERAND_BITS;
  localparam int NC = mma_pkg::NUM_CELLS;

  logic [OW-1:0]      modulus_r;
  logic               accept;
  logic               mod_zero;
  mma_pkg::cell_bus_t chain [NC+1];

  // Modulus register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mma_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      modulus_r <= OW'(cfg_data);
    end
  end

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign mod_zero = (modulus_r == '0);

  // Multiply front end.
  mma_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .mult_left  (OW'(in_mult_left)),
    .mult_right (OW'(in_mult_right)),
    .addend     (OW'(in_addend)),
    .head       (chain[0])
  );

  // Remainder chain, one dividend bit per cell.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    mma_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .modulus (modulus_r),
      .prev    (chain[i]),
      .next    (chain[i+1])
    );
  end

  assign out_valid   = chain[NC].valid;
  assign out_residue = mod_zero ? '0 : mma_pkg::FIELD_W'(chain[NC].rem);

`ifndef SYNTHESIS
  // Every delivered residue is fully reduced.
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !mod_zero) |-> (out_residue < mma_pkg::FIELD_W'(modulus_r)))
    else $error("residue not below the modulus");
`endif

endmodule
